>>> hw/rtl/cobsr_pkg.sv
// cobsr_pkg: shared types and constants for the cobs/r stream decoder
// used by cobsr_step_logic and cobsr_stream_decoder_unit; no dependencies
package cobsr_pkg;

    localparam logic [7:0] FULL_CODE   = 8'hFF;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QPTR_W      = 2;
    localparam int         QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] group_left;
        logic [7:0] group_code;
        logic       frame_open;
        logic       discarding;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       bad_frame;
        logic       run_last;
    } result_t;

endpackage

>>> hw/rtl/cobsr_in_if.sv
// cobsr_in_if: valid/ready channel carrying one encoded byte per transaction
// no dependencies
interface cobsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_last;

    modport source (output valid, output in_byte, output frame_last, input ready);
    modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

>>> hw/rtl/cobsr_out_if.sv
// cobsr_out_if: valid/ready channel carrying one decoded result per transaction
// no dependencies
interface cobsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       bad_frame;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_valid, output frame_end,
                    output bad_frame, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                    input bad_frame, input run_last, output ready);
endinterface

>>> hw/rtl/cobsr_step_logic.sv
// cobsr_step_logic: combinational decode of one encoded byte against the group state
// gives next state and up to two results; depends on cobsr_pkg
module cobsr_step_logic (
    input  cobsr_pkg::dec_state_t state,
    input  logic [7:0]            in_byte,
    input  logic                  frame_last,
    output cobsr_pkg::dec_state_t state_next,
    output cobsr_pkg::result_t    res0,
    output cobsr_pkg::result_t    res1,
    output logic [1:0]            n_results
);

    always_comb
    begin
        logic       is_code;
        logic       first_en;
        logic [7:0] first_byte;
        logic [7:0] left_new;
        logic [7:0] tail_byte;
        logic       tail_en;

        is_code    = (state.group_left == 8'd0);
        first_en   = is_code ? (state.frame_open && (state.group_code != cobsr_pkg::FULL_CODE))
                             : 1'b1;
        first_byte = is_code ? 8'd0 : in_byte;
        left_new   = is_code ? (in_byte - 8'd1) : (state.group_left - 8'd1);
        tail_byte  = is_code ? in_byte : state.group_code;
        tail_en    = frame_last && (left_new != 8'd0);

        res0       = '0;
        res1       = '0;
        n_results  = 2'd0;
        state_next = state;

        if (state.discarding || (in_byte == 8'd0))
        begin
            if (frame_last)
            begin
                res0.frame_end = 1'b1;
                res0.bad_frame = 1'b1;
                res0.run_last  = 1'b1;
                n_results      = 2'd1;
                state_next     = '0;
            end
            else
            begin
                state_next.discarding = 1'b1;
            end
        end
        else
        begin
            state_next.group_left = left_new;
            state_next.frame_open = 1'b1;
            if (is_code)
            begin
                state_next.group_code = in_byte;
            end

            if (first_en && tail_en)
            begin
                res0.out_byte   = first_byte;
                res0.byte_valid = 1'b1;
                res1.out_byte   = tail_byte;
                res1.byte_valid = 1'b1;
                res1.frame_end  = frame_last;
                res1.run_last   = 1'b1;
                n_results       = 2'd2;
            end
            else if (first_en || tail_en)
            begin
                res0.out_byte   = first_en ? first_byte : tail_byte;
                res0.byte_valid = 1'b1;
                res0.frame_end  = frame_last;
                res0.run_last   = 1'b1;
                n_results       = 2'd1;
            end
            else if (frame_last)
            begin
                res0.frame_end = 1'b1;
                res0.run_last  = 1'b1;
                n_results      = 2'd1;
            end

            if (frame_last)
            begin
                state_next = '0;
            end
        end
    end

endmodule

>>> hw/rtl/cobsr_stream_decoder_unit.sv
// cobsr_stream_decoder_unit: top level of the cobs/r stream decoder
// depends on cobsr_pkg, cobsr_in_if, cobsr_out_if and cobsr_step_logic
//
// usage:
// in_stream carries one encoded byte per transaction, frame_last on the final
// byte of a frame. out_stream carries decoded results: out_byte with byte_valid,
// frame_end on the last result of a frame, bad_frame when the frame held a zero
// byte, run_last on the last result caused by one input byte.
// each accepted byte is decoded in the cycle it is accepted and its zero, one or
// two results are registered into a four-entry result queue, whose head is
// offered on out_stream whenever the queue is not empty.
// throughput is one byte per cycle while each byte gives at most one result
// and the receiver takes every result; in_stream.ready is high while the queue
// holds two entries or fewer, so bytes that give two results can fill it.
// when the receiver stalls the queue fills and in_stream.ready drops until
// room for two results is free again; nothing is lost or repeated.
// reset empties the queue and returns the decoder to the start of a frame.
module cobsr_stream_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    cobsr_in_if.sink           in_stream,
    cobsr_out_if.source        out_stream
);

    cobsr_pkg::dec_state_t                state_reg;
    cobsr_pkg::dec_state_t                state_next;
    cobsr_pkg::result_t                   res0;
    cobsr_pkg::result_t                   res1;
    logic [1:0]                           n_results;
    cobsr_pkg::result_t                   queue_mem [cobsr_pkg::QUEUE_DEPTH];
    logic [cobsr_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [cobsr_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [cobsr_pkg::QCNT_W-1:0]         count_reg;
    logic [cobsr_pkg::QCNT_W-1:0]         count_next;
    logic                                 in_accept;
    logic                                 out_accept;
    logic [1:0]                           n_push;
    cobsr_pkg::result_t                   head;

    cobsr_step_logic u_step (
        .state      (state_reg),
        .in_byte    (in_stream.in_byte),
        .frame_last (in_stream.frame_last),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .n_results  (n_results)
    );

    assign in_stream.ready = (count_reg < cobsr_pkg::QCNT_W'(3));
    assign in_accept       = in_stream.valid && in_stream.ready;
    assign out_accept      = out_stream.valid && out_stream.ready;
    assign n_push          = in_accept ? n_results : 2'd0;
    assign count_next      = count_reg + cobsr_pkg::QCNT_W'(n_push)
                             - cobsr_pkg::QCNT_W'(out_accept);

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2)
        begin
            queue_mem[wr_ptr_reg + cobsr_pkg::QPTR_W'(1)] <= res1;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + cobsr_pkg::QPTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + cobsr_pkg::QPTR_W'(out_accept);
            count_reg  <= count_next;
        end
    end

    assign head                  = queue_mem[rd_ptr_reg];
    assign out_stream.valid      = (count_reg != '0);
    assign out_stream.out_byte   = head.out_byte;
    assign out_stream.byte_valid = head.byte_valid;
    assign out_stream.frame_end  = head.frame_end;
    assign out_stream.bad_frame  = head.bad_frame;
    assign out_stream.run_last   = head.run_last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cobsr_pkg::QCNT_W'(cobsr_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[cobsr_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_bad_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_stream.valid && out_stream.bad_frame) |->
        (out_stream.frame_end && !out_stream.byte_valid))
        else $error("bad_frame outside an empty frame end result");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_stream.valid && out_stream.frame_end) |-> out_stream.run_last)
        else $error("frame end result not marked run_last");

    a_fresh_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_stream.frame_last) |=> (state_reg == '0))
        else $error("state not cleared after frame end");

endmodule

>>> tb/cobsr_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps
// cobsr_stream_decoder_unit_tb: self-checking bench for the cobs/r stream decoder,
// a directed table then random frames checked against a behavioural decoder
// depends on cobsr_pkg, cobsr_in_if, cobsr_out_if and cobsr_stream_decoder_unit
module cobsr_stream_decoder_unit_tb;

    localparam logic [7:0] FULL_GROUP   = 8'hFF;
    localparam int         RANDOM_BYTES = 1450;
    localparam int         LIMIT_NS     = 2_000_000;
    localparam int         HOLD_CYCLES  = 120;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       bad_frame;
        logic       run_last;
    } dec_result_t;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        frame_last;
        logic        typed;
        logic [1:0]  n_typed;
        dec_result_t res0;
        dec_result_t res1;
    } stim_t;

    localparam dec_result_t NO_RES    = '0;
    localparam dec_result_t EMPTY_END = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam dec_result_t BAD_END   = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

    localparam int DIRECTED_ROWS = 23;
    localparam stim_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h01, 1'b1, 1'b1, 2'd1, EMPTY_END, NO_RES},
        '{8'h00, 1'b1, 1'b1, 2'd1, BAD_END, NO_RES},
        '{8'h00, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h55, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'hFF, 1'b1, 1'b1, 2'd1, BAD_END, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}, NO_RES},
        '{8'h01, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h03, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h11, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h22, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h80, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h05, 1'b1, 1'b1, 2'd1, '{8'h05, 1'b1, 1'b1, 1'b0, 1'b1}, NO_RES},
        '{8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h07, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h01, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h01, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h02, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h03, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h44, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h12, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic clk;
    logic rst_n;

    cobsr_in_if  in_if ();
    cobsr_out_if out_if ();

    cobsr_stream_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    stim_t       byte_stream [$];
    dec_result_t pending_results [$];
    int          bytes_taken = 0;
    int          error_count = 0;

    logic [7:0] bytes_left;
    logic [7:0] cur_code;
    logic       in_frame;
    logic       drop_rest;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void decode_byte(input logic [7:0] b, input logic last,
                                        input bit keep);
        dec_result_t r [2];
        int          n;
        n = 0;
        r[0] = NO_RES;
        r[1] = NO_RES;
        if (drop_rest || b == 8'h00)
        begin
            if (!last)
                drop_rest = 1'b1;
            else
            begin
                r[0] = BAD_END;
                n = 1;
            end
        end
        else
        begin
            if (bytes_left == 8'h00)
            begin
                if (in_frame && cur_code != FULL_GROUP)
                begin
                    r[n] = '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0};
                    n++;
                end
                cur_code   = b;
                bytes_left = b - 8'h01;
                in_frame   = 1'b1;
            end
            else
            begin
                r[n] = '{b, 1'b1, 1'b0, 1'b0, 1'b0};
                n++;
                bytes_left = bytes_left - 8'h01;
            end
            // cobs/r reduction: short final group gives its code as data
            if (last && bytes_left != 8'h00)
            begin
                r[n] = '{cur_code, 1'b1, 1'b0, 1'b0, 1'b0};
                n++;
            end
            if (last && n == 0)
            begin
                r[0] = EMPTY_END;
                n = 1;
            end
        end
        if (last)
        begin
            r[n-1].frame_end = 1'b1;
            bytes_left = 8'h00;
            cur_code   = 8'h00;
            in_frame   = 1'b0;
            drop_rest  = 1'b0;
        end
        if (n > 0)
            r[n-1].run_last = 1'b1;
        if (keep)
            for (int i = 0; i < n; i++)
                pending_results.push_back(r[i]);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic last);
        byte_stream.push_back('{b, last, 1'b0, 2'd0, NO_RES, NO_RES});
    endfunction

    // groups of random content, the last one cut short half of the time
    function automatic void add_frame(input bit lead_full, input bit poison);
        int start;
        int ngroups;
        int code;
        int ndata;
        int pick;
        bit is_tail;
        start   = byte_stream.size();
        ngroups = lead_full ? 2 : $urandom_range(1, 3);
        for (int g = 0; g < ngroups; g++)
        begin
            pick = $urandom_range(0, 99);
            if ((lead_full && g == 0) || pick < 2)
                code = 255;
            else if (pick < 45)
                code = $urandom_range(1, 8);
            else
                code = $urandom_range(1, 20);
            is_tail = (g == ngroups - 1);
            ndata   = code - 1;
            if (is_tail && code > 1 && $urandom_range(0, 1))
                ndata = $urandom_range(0, code - 2);
            add_byte(code[7:0], is_tail && ndata == 0);
            for (int k = 0; k < ndata; k++)
                add_byte(8'($urandom_range(1, 255)), is_tail && k == ndata - 1);
        end
        if (poison)
            byte_stream[$urandom_range(start, byte_stream.size() - 1)].in_byte = 8'h00;
    endfunction

    function automatic void build_random_stream();
        int kind;
        int len;
        add_frame(1'b1, 1'b0);
        while (byte_stream.size() < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
                add_frame(1'b0, 1'b0);
            else if (kind < 85)
                add_frame(1'b0, 1'b1);
            else
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    add_byte(($urandom_range(0, 3) == 0) ? 8'h00
                                                         : 8'($urandom_range(0, 255)),
                             k == len - 1);
            end
        end
    endfunction

    task automatic feed_bytes();
        int gap_left;
        int burst_left;
        int on_bus;
        gap_left   = 0;
        burst_left = $urandom_range(1, 40);
        on_bus     = -1;
        do
        begin
            @(negedge clk);
            if (in_if.valid && bytes_taken > on_bus)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(1, 6);
                        default: gap_left = $urandom_range(10, 20);
                    endcase
                end
            end
            if (!in_if.valid || bytes_taken > on_bus)
            begin
                if (gap_left > 0 || bytes_taken == byte_stream.size())
                begin
                    in_if.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    in_if.valid      <= 1'b1;
                    in_if.in_byte    <= byte_stream[bytes_taken].in_byte;
                    in_if.frame_last <= byte_stream[bytes_taken].frame_last;
                    on_bus = bytes_taken;
                end
            end
        end
        while (bytes_taken < byte_stream.size() || in_if.valid);
    endtask

    // receiver: random stall patterns plus two long hold-offs to fill the queue
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int holds_done;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        out_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < 2 && bytes_taken >= 300 + 600 * holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= mode_left[1];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        dec_result_t want;
        stim_t       item;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with none expected: out_byte %0h", out_if.out_byte);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %0h actual %0h", want.out_byte,
                               out_if.out_byte);
                        error_count++;
                    end
                    if (out_if.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid expected %0b actual %0b", want.byte_valid,
                               out_if.byte_valid);
                        error_count++;
                    end
                    if (out_if.frame_end !== want.frame_end)
                    begin
                        $error("frame_end expected %0b actual %0b", want.frame_end,
                               out_if.frame_end);
                        error_count++;
                    end
                    if (out_if.bad_frame !== want.bad_frame)
                    begin
                        $error("bad_frame expected %0b actual %0b", want.bad_frame,
                               out_if.bad_frame);
                        error_count++;
                    end
                    if (out_if.run_last !== want.run_last)
                    begin
                        $error("run_last expected %0b actual %0b", want.run_last,
                               out_if.run_last);
                        error_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready && bytes_taken < byte_stream.size())
            begin
                item = byte_stream[bytes_taken];
                decode_byte(in_if.in_byte, in_if.frame_last, !item.typed);
                if (item.typed && item.n_typed > 0)
                    pending_results.push_back(item.res0);
                if (item.typed && item.n_typed > 1)
                    pending_results.push_back(item.res1);
                bytes_taken++;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.in_byte    = 8'h00;
        in_if.frame_last = 1'b0;
        bytes_left       = 8'h00;
        cur_code         = 8'h00;
        in_frame         = 1'b0;
        drop_rest        = 1'b0;
        foreach (DIRECTED[i])
            byte_stream.push_back(DIRECTED[i]);
        build_random_stream();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        feed_bytes();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> cobsr_stream_decoder_unit.f
hw/rtl/cobsr_pkg.sv
hw/rtl/cobsr_in_if.sv
hw/rtl/cobsr_out_if.sv
hw/rtl/cobsr_step_logic.sv
hw/rtl/cobsr_stream_decoder_unit.sv
tb/cobsr_stream_decoder_unit_tb.sv
